// ===== sv/hwc_pkg.sv =====
package hwc_pkg;

  localparam int PHASE_BITS = 24;
  localparam int STEP_W = 24;
  localparam int SUM_W = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
  localparam int CHAN_W = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = REG_IDX_W'(0);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6711);

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic   valid;
    phase_t phase;
  } stage_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

endpackage

// ===== sv/hwc_cfg_regs.sv =====
module hwc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hwc_pkg::PADDR_W-1:0]  paddr,
  input  logic [hwc_pkg::PDATA_W-1:0]  pwdata,
  output logic [hwc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output hwc_pkg::step_t               phase_step
);

  hwc_pkg::step_t step_r;
  hwc_pkg::step_t step_nxt;
  logic [hwc_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[hwc_pkg::PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    step_nxt = step_r;
    if (wr_en && (reg_idx == hwc_pkg::REG_PHASE_STEP)) begin
      step_nxt = pwdata[hwc_pkg::STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= hwc_pkg::STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == hwc_pkg::REG_PHASE_STEP) begin
      prdata = hwc_pkg::PDATA_W'(step_r);
    end
  end

  assign phase_step = step_r;

endmodule

// ===== sv/hwc_phase_acc.sv =====
module hwc_phase_acc (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            advance,
  input  logic            drain,
  input  hwc_pkg::step_t  phase_step,
  output hwc_pkg::stage_t stage
);

  hwc_pkg::phase_t phase_r;
  hwc_pkg::phase_t phase_nxt;
  hwc_pkg::phase_t stage_phase_r;
  logic stage_valid_r;
  logic stage_valid_nxt;
  logic [hwc_pkg::SUM_W-1:0] sum;

  // Sum reaching one full turn clears the phase instead of wrapping.
  always_comb begin
    sum = hwc_pkg::SUM_W'(phase_r) + hwc_pkg::SUM_W'(phase_step);
    phase_nxt = phase_r;
    if (advance) begin
      if (sum[hwc_pkg::SUM_W-1:hwc_pkg::PHASE_BITS] != '0) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = sum[hwc_pkg::PHASE_BITS-1:0];
      end
    end
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (drain) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_phase_r <= phase_nxt;
    end
  end

  assign stage.valid = stage_valid_r;
  assign stage.phase = stage_phase_r;

endmodule

// ===== sv/hwc_rgb_conv.sv =====
module hwc_rgb_conv (
  input  logic            clk,
  input  logic            rst_n,
  input  hwc_pkg::stage_t stage,
  input  logic            load,
  input  logic            unload,
  output logic            valid,
  output hwc_pkg::rgb_t   rgb
);

  localparam int PB = hwc_pkg::PHASE_BITS;

  logic [PB+2:0] scaled;
  logic [2:0] sector;
  logic [PB-1:0] frac;
  logic [PB:0] fall;
  logic [PB+8:0] ramp_prod;
  hwc_pkg::chan_t ramp;
  hwc_pkg::rgb_t rgb_nxt;
  hwc_pkg::rgb_t rgb_r;
  logic valid_r;
  logic valid_nxt;

  always_comb begin
    scaled = (PB+3)'(stage.phase) * (PB+3)'(6);
    sector = scaled[PB+2:PB];
    frac = scaled[PB-1:0];
    fall = {1'b1, {PB{1'b0}}} - {1'b0, frac};
    if (sector[0]) begin
      ramp_prod = (PB+9)'(fall) * (PB+9)'(255);
    end else begin
      ramp_prod = (PB+9)'(frac) * (PB+9)'(255);
    end
    ramp = ramp_prod[PB+7:PB];
  end

  always_comb begin
    case (sector)
      3'd0: rgb_nxt = '{red: 8'd255, green: ramp, blue: 8'd0};
      3'd1: rgb_nxt = '{red: ramp, green: 8'd255, blue: 8'd0};
      3'd2: rgb_nxt = '{red: 8'd0, green: 8'd255, blue: ramp};
      3'd3: rgb_nxt = '{red: 8'd0, green: ramp, blue: 8'd255};
      3'd4: rgb_nxt = '{red: ramp, green: 8'd0, blue: 8'd255};
      default: rgb_nxt = '{red: 8'd255, green: 8'd0, blue: ramp};
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (unload) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign valid = valid_r;
  assign rgb = rgb_r;

endmodule

// ===== sv/hue_wheel_color_cycler.sv =====
// Path: an accepted word is registered in the phase stage, then moves into the result register
// when the output side is free, and it leaves the block from there.
// Throughput: one word per cycle; a word is accepted each cycle the phase stage is free
// or moves on; in_ready follows out_ready combinationally once both registers hold words.
// Reset: synchronous, active-low rst_n clears the hue phase to zero, empties both stages
// and sets phase_step to 6711.
module hue_wheel_color_cycler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_advance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hwc_pkg::PADDR_W-1:0]  paddr,
  input  logic [hwc_pkg::PDATA_W-1:0]  pwdata,
  output logic [hwc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  hwc_pkg::step_t phase_step;
  hwc_pkg::stage_t stage;
  hwc_pkg::rgb_t rgb;
  logic accept;
  logic out_free;
  logic stage_move;

  assign out_free = !out_valid || out_ready;
  assign stage_move = stage.valid && out_free;
  assign in_ready = !stage.valid || stage_move;
  assign accept = in_valid && in_ready;

  hwc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .phase_step (phase_step)
  );

  hwc_phase_acc u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .advance    (in_advance),
    .drain      (stage_move),
    .phase_step (phase_step),
    .stage      (stage)
  );

  hwc_rgb_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .load   (stage_move),
    .unload (out_ready),
    .valid  (out_valid),
    .rgb    (rgb)
  );

  assign out_red = rgb.red;
  assign out_green = rgb.green;
  assign out_blue = rgb.blue;

endmodule

// ===== sv/hwc_checker.sv =====
module hwc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("Output word changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_full_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == 8'd255 || out_green == 8'd255 || out_blue == 8'd255)
      && (out_red == 8'd0 || out_green == 8'd0 || out_blue == 8'd0))
    else $error("Output color is not on the hue wheel.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("Accepted word did not reach the output in two cycles.");

endmodule

bind hue_wheel_color_cycler hwc_checker u_hwc_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int RAND_WORDS = 1700;
  localparam int LIMIT = 500000;
  localparam int BAD_REG_IDX = 1;
  localparam logic [hwc_pkg::PADDR_W-1:0] STEP_ADDR =
    hwc_pkg::PADDR_W'(int'(hwc_pkg::REG_PHASE_STEP) * 4);
  localparam logic [hwc_pkg::PADDR_W-1:0] BAD_ADDR = hwc_pkg::PADDR_W'(BAD_REG_IDX * 4);
  localparam hwc_pkg::rgb_t PURE_RED = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
  localparam hwc_pkg::rgb_t NO_RGB = '0;

  typedef struct packed {
    bit                          wr;
    logic [hwc_pkg::PADDR_W-1:0] addr;
    logic [31:0]                 data;
    bit                          adv;
    bit                          known;
    hwc_pkg::rgb_t               rgb;
  } dir_row_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b0, 1'b1, PURE_RED},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b1, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b1, BAD_ADDR,  32'h00AB_CDEF, 1'b1, 1'b0, NO_RGB},
    '{1'b1, STEP_ADDR, 32'hFFFF_FFFF, 1'b1, 1'b1, PURE_RED},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b1, PURE_RED},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b1, PURE_RED},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b0, 1'b1, PURE_RED},
    '{1'b1, STEP_ADDR, 32'h002A_AAAB, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b1, PURE_RED},
    '{1'b1, STEP_ADDR, 32'h0015_5555, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b0, 1'b0, NO_RGB},
    '{1'b1, STEP_ADDR, 32'h0080_0000, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b1, 1'b1, PURE_RED},
    '{1'b1, STEP_ADDR, 32'h0000_0001, 1'b1, 1'b0, NO_RGB},
    '{1'b0, STEP_ADDR, 32'h0000_0000, 1'b0, 1'b0, NO_RGB}
  };

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_advance = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_red;
  logic [7:0]                  out_green;
  logic [7:0]                  out_blue;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [hwc_pkg::PADDR_W-1:0] paddr = '0;
  logic [hwc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [hwc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  hwc_pkg::phase_t wheel_pos = '0;
  hwc_pkg::step_t  step_cfg = hwc_pkg::STEP_RESET;
  hwc_pkg::rgb_t   pending_rgb [$];
  hwc_pkg::rgb_t   want_rgb;
  int              err_cnt = 0;
  int              cycles = 0;
  int              tx_gap_max = 9;
  int              rx_gap_max = 9;

  hue_wheel_color_cycler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_advance(in_advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL hue_wheel_color_cycler");
      $finish;
    end
  end

  function automatic hwc_pkg::rgb_t hue_to_rgb(hwc_pkg::phase_t ph);
    longint unsigned one;
    longint unsigned scaled;
    longint unsigned frac;
    longint unsigned sector;
    hwc_pkg::chan_t ramp;
    hwc_pkg::rgb_t c;
    one = 64'd1 << hwc_pkg::PHASE_BITS;
    scaled = 64'(ph) * 6;
    sector = scaled >> hwc_pkg::PHASE_BITS;
    frac = scaled & (one - 1);
    if (sector[0]) begin
      ramp = hwc_pkg::chan_t'(((one - frac) * 255) >> hwc_pkg::PHASE_BITS);
    end else begin
      ramp = hwc_pkg::chan_t'((frac * 255) >> hwc_pkg::PHASE_BITS);
    end
    case (sector)
      0: c = '{red: 8'hFF, green: ramp, blue: 8'h00};
      1: c = '{red: ramp, green: 8'hFF, blue: 8'h00};
      2: c = '{red: 8'h00, green: 8'hFF, blue: ramp};
      3: c = '{red: 8'h00, green: ramp, blue: 8'hFF};
      4: c = '{red: ramp, green: 8'h00, blue: 8'hFF};
      default: c = '{red: 8'hFF, green: 8'h00, blue: ramp};
    endcase
    return c;
  endfunction

  // The phase is cleared, not wrapped, once the sum reaches a full turn.
  function automatic hwc_pkg::rgb_t advance_wheel(bit adv);
    logic [hwc_pkg::SUM_W-1:0] sum;
    sum = hwc_pkg::SUM_W'(wheel_pos) + hwc_pkg::SUM_W'(step_cfg);
    if (adv) begin
      wheel_pos = (sum >= (hwc_pkg::SUM_W'(1) << hwc_pkg::PHASE_BITS)) ?
        '0 : hwc_pkg::phase_t'(sum);
    end
    return hue_to_rgb(wheel_pos);
  endfunction

  task automatic send_word(bit adv, bit known, hwc_pkg::rgb_t typed);
    int gap;
    hwc_pkg::rgb_t next_rgb;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_advance <= adv;
    do @(posedge clk); while (!in_ready);
    next_rgb = advance_wheel(adv);
    pending_rgb.push_back(known ? typed : next_rgb);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [hwc_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    logic [hwc_pkg::PDATA_W-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == STEP_ADDR) begin
      step_cfg = data[hwc_pkg::STEP_W-1:0];
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == STEP_ADDR && rd[hwc_pkg::STEP_W-1:0] !== step_cfg) begin
      $error("phase_step readback: expected %0h, got %0h", step_cfg,
        rd[hwc_pkg::STEP_W-1:0]);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        err_cnt++;
      end else begin
        want_rgb = pending_rgb.pop_front();
        if (out_red !== want_rgb.red) begin
          $error("red: expected %0d, got %0d", want_rgb.red, out_red);
          err_cnt++;
        end
        if (out_green !== want_rgb.green) begin
          $error("green: expected %0d, got %0d", want_rgb.green, out_green);
          err_cnt++;
        end
        if (out_blue !== want_rgb.blue) begin
          $error("blue: expected %0d, got %0d", want_rgb.blue, out_blue);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int rx_gap;
    wait (rst_n === 1'b1);
    forever begin
      rx_gap = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      @(negedge clk);
      repeat (rx_gap) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int n_words;
    int run_len;
    hwc_pkg::step_t new_step;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].wr) begin
        drain();
        write_reg(DIR_TAB[i].addr, DIR_TAB[i].data);
      end
      send_word(DIR_TAB[i].adv, DIR_TAB[i].known, DIR_TAB[i].rgb);
    end

    n_words = 0;
    while (n_words < RAND_WORDS) begin
      drain();
      if ($urandom_range(0, 4) == 0) begin
        write_reg(BAD_ADDR, $urandom());
      end
      case ($urandom_range(0, 5))
        0: new_step = '0;
        1: new_step = '1;
        2: new_step = hwc_pkg::step_t'($urandom_range(1, 64));
        3: new_step = hwc_pkg::step_t'($urandom());
        4: new_step = hwc_pkg::step_t'($urandom_range(24'h008000, 24'h200000));
        default: new_step = hwc_pkg::STEP_RESET;
      endcase
      write_reg(STEP_ADDR, {8'($urandom()), new_step});
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      run_len = $urandom_range(20, 200);
      if (run_len > RAND_WORDS - n_words) begin
        run_len = RAND_WORDS - n_words;
      end
      repeat (run_len) begin
        send_word($urandom_range(0, 3) != 0, 1'b0, NO_RGB);
        n_words++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS hue_wheel_color_cycler");
    end else begin
      $display("FAIL hue_wheel_color_cycler");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hwc_pkg.sv
sv/hwc_cfg_regs.sv
sv/hwc_phase_acc.sv
sv/hwc_rgb_conv.sv
sv/hue_wheel_color_cycler.sv
sv/hwc_checker.sv
verif/tb.sv
